// ===== rtl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and codes for the time-slice scheduler.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam logic CMD_SCHED = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESCAN
  } tss_state_e;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic write;
    logic recharge;
  } tss_ctrl_t;

endpackage

// ===== rtl/tss_cell.sv =====
// ----------------------------------------------------------------------------
// tss_cell
// One task table entry plus one stage of the best-candidate ripple chain.
// ----------------------------------------------------------------------------
module tss_cell
  import tss_pkg::*;
#(
  parameter int CELL_IDX   = 0,
  parameter int TASK_W     = 6,
  parameter int SLICE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tss_ctrl_t             ctrl_i,
  input  logic                  wr_hit_i,
  input  logic [SLICE_BITS-1:0] wr_prio_i,
  input  logic [SLICE_BITS-1:0] wr_slice_i,
  input  logic                  wr_run_i,
  input  logic [TASK_W-1:0]     cur_task_i,
  input  logic                  found_i,
  input  logic [TASK_W-1:0]     idx_i,
  input  logic [SLICE_BITS-1:0] val_i,
  input  logic                  cur_ok_i,
  output logic                  found_o,
  output logic [TASK_W-1:0]     idx_o,
  output logic [SLICE_BITS-1:0] val_o,
  output logic                  cur_ok_o
);

  logic                  run_q, run_d;
  logic [SLICE_BITS-1:0] slice_q, slice_d;
  logic [SLICE_BITS-1:0] prio_q, prio_d;
  logic                  found_q, found_d;
  logic                  cur_ok_q, cur_ok_d;
  logic [TASK_W-1:0]     idx_q, idx_d;
  logic [SLICE_BITS-1:0] val_q, val_d;
  logic                  take;
  logic                  is_cur;

  always_comb begin
    run_d   = run_q;
    slice_d = slice_q;
    prio_d  = prio_q;
    if (ctrl_i.write && wr_hit_i) begin
      run_d   = wr_run_i;
      slice_d = wr_slice_i;
      prio_d  = wr_prio_i;
    end else if (ctrl_i.recharge && run_q) begin
      slice_d = prio_q;
    end
  end

  assign take     = run_q && (!found_i || (slice_q > val_i));
  assign is_cur   = (cur_task_i == TASK_W'(CELL_IDX));
  assign found_d  = found_i | run_q;
  assign idx_d    = take ? TASK_W'(CELL_IDX) : idx_i;
  assign val_d    = take ? slice_q : val_i;
  assign cur_ok_d = cur_ok_i | (is_cur && run_q && (slice_q != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      slice_q  <= '0;
      prio_q   <= '0;
      found_q  <= 1'b0;
      cur_ok_q <= 1'b0;
    end else begin
      run_q    <= run_d;
      slice_q  <= slice_d;
      prio_q   <= prio_d;
      found_q  <= found_d;
      cur_ok_q <= cur_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    val_q <= val_d;
  end

  assign found_o  = found_q;
  assign idx_o    = idx_q;
  assign val_o    = val_q;
  assign cur_ok_o = cur_ok_q;

endmodule

// ===== rtl/time_slice_scheduler.sv =====
// ----------------------------------------------------------------------------
// time_slice_scheduler
// Counter-based time-slice scheduler over a chain of task table cells.
// ----------------------------------------------------------------------------
// A table write is taken in the cycle it is accepted and its result strobes on
// done_o in the next cycle. A schedule command holds busy while it scans the
// chain and its result strobes right after; when a recharge is needed it
// recharges and scans the chain a second time instead. The scan length is set
// by the best-candidate search, which ripples one cell per cycle along the
// chain of NUM_TASKS cells. done_o is high for exactly one cycle per command
// and cannot be held off, so results must be captured on that cycle.
module time_slice_scheduler
  import tss_pkg::*;
#(
  parameter int NUM_TASKS  = 64,
  parameter int IDLE_TASK  = 0,
  parameter int SLICE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic        resched_request_i,
  input  logic [5:0]  entry_index_i,
  input  logic [15:0] entry_priority_i,
  input  logic [15:0] entry_remaining_i,
  input  logic        entry_running_i,
  output logic        done_o,
  output logic [5:0]  chosen_index_o,
  output logic        switched_o,
  output logic        recharged_o,
  output logic        kept_current_o
);

  localparam int TASK_SPAN = (NUM_TASKS > IDLE_TASK + 1) ? NUM_TASKS : IDLE_TASK + 1;
  localparam int TASK_W    = $clog2(TASK_SPAN);
  localparam int CNT_W     = $clog2(NUM_TASKS + 1);

  tss_state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              resched_q, resched_d;
  logic [TASK_W-1:0] cur_q, cur_d;
  logic              done_q, done_d;
  logic [TASK_W-1:0] chosen_q, chosen_d;
  logic              switched_q, switched_d;
  logic              rech_q, rech_d;
  logic              kept_q, kept_d;

  tss_ctrl_t ctrl;
  logic      accept;

  logic [SLICE_BITS-1:0] wr_prio;
  logic [SLICE_BITS-1:0] wr_slice;
  logic [NUM_TASKS-1:0]  wr_hit;

  logic [NUM_TASKS:0]                 ch_found;
  logic [NUM_TASKS:0][TASK_W-1:0]     ch_idx;
  logic [NUM_TASKS:0][SLICE_BITS-1:0] ch_val;
  logic [NUM_TASKS:0]                 ch_cur_ok;

  logic              tail_found;
  logic [TASK_W-1:0] tail_idx;
  logic              tail_nonzero;
  logic              tail_cur_ok;

  assign accept   = start && !busy;
  assign wr_prio  = SLICE_BITS'(entry_priority_i);
  assign wr_slice = SLICE_BITS'(entry_remaining_i);

  assign ch_found[0]  = 1'b0;
  assign ch_idx[0]    = '0;
  assign ch_val[0]    = '0;
  assign ch_cur_ok[0] = 1'b0;

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    if (i < 64) begin : g_hit
      assign wr_hit[i] = (entry_index_i == 6'(i));
    end else begin : g_nohit
      assign wr_hit[i] = 1'b0;
    end

    tss_cell #(
      .CELL_IDX  (i),
      .TASK_W    (TASK_W),
      .SLICE_BITS(SLICE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .wr_hit_i  (wr_hit[i]),
      .wr_prio_i (wr_prio),
      .wr_slice_i(wr_slice),
      .wr_run_i  (entry_running_i),
      .cur_task_i(cur_q),
      .found_i   (ch_found[i]),
      .idx_i     (ch_idx[i]),
      .val_i     (ch_val[i]),
      .cur_ok_i  (ch_cur_ok[i]),
      .found_o   (ch_found[i+1]),
      .idx_o     (ch_idx[i+1]),
      .val_o     (ch_val[i+1]),
      .cur_ok_o  (ch_cur_ok[i+1])
    );
  end

  assign tail_found   = ch_found[NUM_TASKS];
  assign tail_idx     = ch_idx[NUM_TASKS];
  assign tail_nonzero = (ch_val[NUM_TASKS] != '0);
  assign tail_cur_ok  = ch_cur_ok[NUM_TASKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      resched_q <= 1'b0;
      cur_q     <= TASK_W'(IDLE_TASK);
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      resched_q <= resched_d;
      cur_q     <= cur_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chosen_q   <= chosen_d;
    switched_q <= switched_d;
    rech_q     <= rech_d;
    kept_q     <= kept_d;
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    resched_d     = resched_q;
    cur_d         = cur_q;
    done_d        = 1'b0;
    chosen_d      = chosen_q;
    switched_d    = switched_q;
    rech_d        = rech_q;
    kept_d        = kept_q;
    ctrl.write    = 1'b0;
    ctrl.recharge = 1'b0;
    busy          = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          if (cmd_i == CMD_WRITE) begin
            ctrl.write = 1'b1;
            done_d     = 1'b1;
            chosen_d   = cur_q;
            switched_d = 1'b0;
            rech_d     = 1'b0;
            kept_d     = 1'b0;
          end else begin
            resched_d = resched_request_i;
            cnt_d     = '0;
            state_d   = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (cnt_q == CNT_W'(NUM_TASKS)) begin
          if (!resched_q && tail_cur_ok) begin
            done_d     = 1'b1;
            chosen_d   = cur_q;
            switched_d = 1'b0;
            rech_d     = 1'b0;
            kept_d     = 1'b1;
            state_d    = ST_IDLE;
          end else if (!tail_found || tail_nonzero) begin
            done_d     = 1'b1;
            chosen_d   = tail_found ? tail_idx : TASK_W'(IDLE_TASK);
            switched_d = (chosen_d != cur_q);
            rech_d     = 1'b0;
            kept_d     = 1'b0;
            cur_d      = chosen_d;
            state_d    = ST_IDLE;
          end else begin
            ctrl.recharge = 1'b1;
            cnt_d         = '0;
            state_d       = ST_RESCAN;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_RESCAN: begin
        if (cnt_q == CNT_W'(NUM_TASKS)) begin
          done_d     = 1'b1;
          chosen_d   = (tail_found && tail_nonzero) ? tail_idx : TASK_W'(IDLE_TASK);
          switched_d = (chosen_d != cur_q);
          rech_d     = 1'b1;
          kept_d     = 1'b0;
          cur_d      = chosen_d;
          state_d    = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign done_o         = done_q;
  assign chosen_index_o = 6'(chosen_q);
  assign switched_o     = switched_q;
  assign recharged_o    = rech_q;
  assign kept_current_o = kept_q;

endmodule

// ===== rtl/tss_checker.sv =====
// ----------------------------------------------------------------------------
// tss_checker
// Port-level checks for the time-slice scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module tss_checker
  import tss_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        cmd_i,
  input logic        done_o,
  input logic [5:0]  chosen_index_o,
  input logic        switched_o,
  input logic        recharged_o,
  input logic        kept_current_o
);

  // a write transfer answers in the next cycle with all flags clear
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_WRITE) |=>
      (done_o && !switched_o && !recharged_o && !kept_current_o))
    else $error("write transfer without a plain result");

  a_sched_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_SCHED) |=> (busy && !done_o))
    else $error("schedule transfer did not go busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while busy");

  a_kept_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && kept_current_o) |-> (!switched_o && !recharged_o))
    else $error("kept result with switch or recharge");

  a_kept_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && kept_current_o) |-> (chosen_index_o == $past(chosen_index_o) ||
                                    !$past(done_o)))
    else $error("kept result changed task back to back");

endmodule

bind time_slice_scheduler tss_checker u_tss_checker (.*);
